FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion shorthands, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hdl/fbs_pkg.sv
// ----------------------------------------------------------------------------
// fbs_pkg
// shared types and constants of the blink sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package fbs_pkg;

	// field widths
	localparam int unsigned SLEEP_W  = 4;
	localparam int unsigned FAST_W   = 4;
	localparam int unsigned STEADY_W = 16;
	localparam int unsigned LOOP_W   = 16;
	localparam int unsigned BOUND_W  = 4;
	localparam int unsigned WIDEN_W  = 6;
	localparam int unsigned GEN_W    = 8;
	localparam int unsigned TRY_W    = 8;

	// configuration register indexes (byte address bit 2)
	localparam logic REG_FAST   = 1'b0;
	localparam logic REG_STEADY = 1'b1;

	// configuration reset values
	localparam logic [FAST_W-1:0]   FAST_RESET   = 4'd4;
	localparam logic [STEADY_W-1:0] STEADY_RESET = 16'd450;

	// random generator seed
	localparam logic [GEN_W-1:0] GEN_STEP_SEED = 8'hCA;
	localparam logic [GEN_W-1:0] GEN_MIX_SEED  = 8'hFE;
	localparam logic [GEN_W-1:0] GEN_SUM_SEED  = 8'hBA;
	localparam logic [GEN_W-1:0] GEN_OUT_SEED  = 8'hBE;

	// sequencer phases
	typedef enum logic [2:0] {
		PH_DAY,
		PH_FAST,
		PH_RANDX,
		PH_INTERVAL,
		PH_STEADY,
		PH_REST
	} phase_t;

	// controller to datapath commands
	typedef struct packed {
		logic start;   // evaluate the accepted request
		logic draw;    // run one generator try if a draw is pending
		logic load;    // move the finished result into the output register
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic done;    // result complete, no draw pending
	} dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/fbs_in_if.sv
// ----------------------------------------------------------------------------
// fbs_in_if
// wake-up request channel: night flag from the light check
// ----------------------------------------------------------------------------
`default_nettype none

interface fbs_in_if;
	logic valid;
	logic ready;
	logic night_seen;

	modport source (output valid, output night_seen, input ready);
	modport sink (input valid, input night_seen, output ready);
endinterface

`default_nettype wire

FILE: hdl/fbs_out_if.sv
// ----------------------------------------------------------------------------
// fbs_out_if
// result channel: blink decision and next sleep schedule
// ----------------------------------------------------------------------------
`default_nettype none

interface fbs_out_if
	import fbs_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               blink_now;
	logic [SLEEP_W-1:0] sleep_seconds;
	logic               check_after;

	modport source (output valid, output blink_now, output sleep_seconds,
		output check_after, input ready);
	modport sink (input valid, input blink_now, input sleep_seconds,
		input check_after, output ready);
endinterface

`default_nettype wire

FILE: hdl/fbs_ctrl.sv
// ----------------------------------------------------------------------------
// fbs_ctrl
// request sequencing: accept, run pending draws, hand over to output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fbs_ctrl
	import fbs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output dp_cmd_t         cmd,
	input  wire dp_status_t status
);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	// handshake decode
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd.start = accept;
		cmd.draw  = (state_q == S_RUN);
		cmd.load  = (state_q == S_RUN) && status.done && slot_free;
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (cmd.load) begin
						state_q <= S_IDLE;
					end
				end
			endcase
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// checks
	`ASSERT_IMPLIES(a_load_when_done, clk, arst_n, cmd.load, status.done)
	`ASSERT_NEXT(a_accept_runs, clk, arst_n, accept, state_q == S_RUN && !in_ready)
	`ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.load, out_valid_q)
	`ASSERT_IMPLIES(a_no_start_busy, clk, arst_n, cmd.start, !cmd.draw && !cmd.load)

endmodule

`default_nettype wire

FILE: hdl/fbs_datapath.sv
// ----------------------------------------------------------------------------
// fbs_datapath
// phase state, interval bounds, xabc generator with rejection draw, result
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fbs_datapath
	import fbs_pkg::*;
#(
	parameter int unsigned MAX_SLEEP_SECONDS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dp_cmd_t             cmd,
	output dp_status_t               status,
	input  wire logic                night_seen,
	input  wire logic [FAST_W-1:0]   fast_count,
	input  wire logic [STEADY_W-1:0] steady_count,
	output logic                     blink_now,
	output logic [SLEEP_W-1:0]       sleep_seconds,
	output logic                     check_after
);

	localparam logic [SLEEP_W-1:0] MAX_S = SLEEP_W'(MAX_SLEEP_SECONDS);

	typedef enum logic [1:0] {
		M_NONE,
		M_RANDX,
		M_INTERVAL
	} draw_mode_t;

	// sequencer state
	phase_t             phase_q;
	logic [LOOP_W-1:0]  loop_q;
	logic [BOUND_W-1:0] low_q;
	logic [BOUND_W-1:0] high_q;
	logic [WIDEN_W-1:0] widen_q;
	logic [GEN_W-1:0]   gen_step_q;
	logic [GEN_W-1:0]   gen_mix_q;
	logic [GEN_W-1:0]   gen_sum_q;
	logic [GEN_W-1:0]   gen_out_q;
	draw_mode_t         mode_q;
	logic [TRY_W-1:0]   tries_q;

	// pending result and draw operands
	logic               res_blink_q;
	logic [SLEEP_W-1:0] res_sleep_q;
	logic               res_check_q;
	logic [BOUND_W-1:0] draw_n_q;
	logic [BOUND_W-1:0] draw_base_q;

	// output register
	logic               out_blink_q;
	logic [SLEEP_W-1:0] out_sleep_q;
	logic               out_check_q;

	// next-state values for an accepted request
	phase_t             nx_phase;
	logic [LOOP_W-1:0]  nx_loop;
	logic [BOUND_W-1:0] nx_low;
	logic [BOUND_W-1:0] nx_high;
	logic [WIDEN_W-1:0] nx_widen;
	logic               nx_blink;
	logic [SLEEP_W-1:0] nx_sleep;
	logic               nx_check;
	draw_mode_t         nx_mode;
	logic [BOUND_W-1:0] nx_n;
	logic [BOUND_W-1:0] nx_base;

	logic [LOOP_W-1:0]  lc_inc;
	logic [WIDEN_W-1:0] w_inc;
	logic [BOUND_W-1:0] h_inc;
	logic [BOUND_W-1:0] l_inc;
	logic [LOOP_W-1:0]  fast_ext;
	logic               fast_done;

	// generator try
	logic [GEN_W-1:0]   g_step;
	logic [GEN_W-1:0]   g_mix;
	logic [GEN_W-1:0]   g_sum;
	logic [GEN_W-1:0]   g_out;
	logic [2:0]         mask;
	logic [2:0]         v;
	logic               hit;
	logic               exhausted;
	logic [2:0]         pick;
	logic [SLEEP_W-1:0] fin_sleep;
	logic               try_en;

	// counter and bound increments
	assign lc_inc    = loop_q + LOOP_W'(1);
	assign w_inc     = widen_q + WIDEN_W'(1);
	assign h_inc     = (w_inc[1:0] == 2'd0 && high_q < MAX_S) ? high_q + BOUND_W'(1) : high_q;
	assign l_inc     = (w_inc[2:0] == 3'd0) ? low_q + BOUND_W'(1) : low_q;
	assign fast_ext  = LOOP_W'(fast_count);
	assign fast_done = (lc_inc >= fast_ext);

	// phase transition for one request
	always_comb begin
		nx_phase = phase_q;
		nx_loop  = loop_q;
		nx_low   = low_q;
		nx_high  = high_q;
		nx_widen = widen_q;
		nx_blink = 1'b0;
		nx_sleep = MAX_S;
		nx_check = 1'b1;
		nx_mode  = M_NONE;
		nx_n     = BOUND_W'(2);
		nx_base  = BOUND_W'(1);
		unique case (phase_q)
			PH_FAST: begin
				nx_blink = 1'b1;
				if (fast_done) begin
					if (fast_count == '0) begin
						nx_phase = PH_INTERVAL;
						nx_low   = BOUND_W'(1);
						nx_high  = BOUND_W'(2);
						nx_widen = '0;
						nx_mode  = M_INTERVAL;
					end else begin
						nx_phase = PH_RANDX;
						nx_loop  = '0;
						nx_mode  = M_RANDX;
						nx_n     = BOUND_W'(8);
					end
				end else begin
					nx_loop  = lc_inc;
					nx_sleep = SLEEP_W'(1);
					nx_check = 1'b0;
				end
			end
			PH_RANDX: begin
				if (!night_seen) begin
					nx_phase = PH_DAY;
				end else begin
					nx_blink = 1'b1;
					if (fast_done) begin
						nx_phase = PH_INTERVAL;
						nx_low   = BOUND_W'(1);
						nx_high  = BOUND_W'(2);
						nx_widen = '0;
						nx_mode  = M_INTERVAL;
					end else begin
						nx_loop = lc_inc;
						nx_mode = M_RANDX;
						nx_n    = BOUND_W'(8);
					end
				end
			end
			PH_INTERVAL: begin
				if (!night_seen) begin
					nx_phase = PH_DAY;
				end else begin
					nx_blink = 1'b1;
					nx_widen = w_inc;
					nx_high  = h_inc;
					nx_low   = l_inc;
					if (l_inc < MAX_S) begin
						nx_mode = M_INTERVAL;
						nx_n    = h_inc - l_inc + BOUND_W'(1);
						nx_base = l_inc;
					end else begin
						nx_loop  = '0;
						nx_phase = (steady_count == '0) ? PH_REST : PH_STEADY;
					end
				end
			end
			PH_STEADY: begin
				if (!night_seen) begin
					nx_phase = PH_DAY;
				end else begin
					nx_blink = 1'b1;
					nx_loop  = lc_inc;
					if (lc_inc >= steady_count) begin
						nx_phase = PH_REST;
					end
				end
			end
			PH_REST: begin
				if (!night_seen) begin
					nx_phase = PH_DAY;
				end
			end
			default: begin
				// day wait, and any code without meaning
				if (!night_seen) begin
					nx_phase = PH_DAY;
				end else if (fast_count == '0) begin
					nx_phase = PH_INTERVAL;
					nx_low   = BOUND_W'(1);
					nx_high  = BOUND_W'(2);
					nx_widen = '0;
					nx_mode  = M_INTERVAL;
				end else begin
					nx_phase = PH_FAST;
					nx_loop  = '0;
					nx_sleep = SLEEP_W'(1);
					nx_check = 1'b0;
				end
			end
		endcase
	end

	// one xabc step and rejection test
	assign g_step = gen_step_q + GEN_W'(1);
	assign g_mix  = gen_mix_q ^ gen_out_q ^ g_step;
	assign g_sum  = gen_sum_q + g_mix;
	assign g_out  = gen_out_q + ({1'b0, g_sum[GEN_W-1:1]} ^ g_mix);

	always_comb begin
		if (draw_n_q <= BOUND_W'(2)) begin
			mask = 3'b001;
		end else if (draw_n_q <= BOUND_W'(4)) begin
			mask = 3'b011;
		end else begin
			mask = 3'b111;
		end
	end

	assign v         = g_out[2:0] & mask;
	assign hit       = (BOUND_W'(v) < draw_n_q);
	assign exhausted = (tries_q == '1);
	assign pick      = hit ? v : 3'd0;
	assign try_en    = cmd.draw && (mode_q != M_NONE);

	// sleep length from the drawn value
	always_comb begin
		if (mode_q == M_RANDX) begin
			fin_sleep = (LOOP_W'(pick) <= loop_q) ? SLEEP_W'(2) : SLEEP_W'(1);
		end else begin
			fin_sleep = draw_base_q + SLEEP_W'(pick);
		end
	end

	assign status.done = (mode_q == M_NONE);

	// sequencer and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DAY;
			loop_q     <= '0;
			low_q      <= BOUND_W'(1);
			high_q     <= BOUND_W'(2);
			widen_q    <= '0;
			gen_step_q <= GEN_STEP_SEED;
			gen_mix_q  <= GEN_MIX_SEED;
			gen_sum_q  <= GEN_SUM_SEED;
			gen_out_q  <= GEN_OUT_SEED;
			mode_q     <= M_NONE;
			tries_q    <= '0;
		end else begin
			if (cmd.start) begin
				phase_q <= nx_phase;
				loop_q  <= nx_loop;
				low_q   <= nx_low;
				high_q  <= nx_high;
				widen_q <= nx_widen;
				mode_q  <= nx_mode;
				tries_q <= '0;
			end else if (try_en) begin
				gen_step_q <= g_step;
				gen_mix_q  <= g_mix;
				gen_sum_q  <= g_sum;
				gen_out_q  <= g_out;
				if (hit || exhausted) begin
					mode_q <= M_NONE;
				end else begin
					tries_q <= tries_q + TRY_W'(1);
				end
			end
		end
	end

	// result and output payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			res_blink_q <= nx_blink;
			res_sleep_q <= nx_sleep;
			res_check_q <= nx_check;
			draw_n_q    <= nx_n;
			draw_base_q <= nx_base;
		end else if (try_en && (hit || exhausted)) begin
			res_sleep_q <= fin_sleep;
		end
		if (cmd.load) begin
			out_blink_q <= res_blink_q;
			out_sleep_q <= res_sleep_q;
			out_check_q <= res_check_q;
		end
	end

	assign blink_now     = out_blink_q;
	assign sleep_seconds = out_sleep_q;
	assign check_after   = out_check_q;

	// checks
	`ASSERT_IMPLIES(a_draw_checks, clk, arst_n, mode_q != M_NONE, res_check_q && draw_n_q != '0)
	`ASSERT_NEXT(a_try_ends, clk, arst_n, try_en && exhausted, mode_q == M_NONE)
	`ASSERT_IMPLIES(a_sleep_range, clk, arst_n, cmd.load, res_sleep_q != '0 && res_sleep_q <= MAX_S)

endmodule

`default_nettype wire

FILE: hdl/firefly_blink_sequencer_core.sv
// sequencing: a request is accepted only while idle; its draw, if any, runs
//   generator tries until a hit or 256 tries, then the result is registered
//   into the output once the output slot is free; no new request is taken
//   before then; the tries come from rejection over the xabc generator
// reset: arst_n clears phase, counters, bounds, generator state, handshake and
//   config at once; the block then sits in the day wait with a check pending
// ----------------------------------------------------------------------------
// firefly_blink_sequencer_core
// night-time led blink sequencer with apb configuration port
// ----------------------------------------------------------------------------
`default_nettype none

module firefly_blink_sequencer_core
	import fbs_pkg::*;
#(
	parameter int unsigned MAX_SLEEP_SECONDS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	fbs_in_if.sink           in_ch,
	fbs_out_if.source        out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [FAST_W-1:0]   fast_q;
	logic [STEADY_W-1:0] steady_q;
	logic                cfg_wr;
	dp_cmd_t             cmd;
	dp_status_t          status;
	logic                out_valid;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q   <= FAST_RESET;
			steady_q <= STEADY_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FAST:   fast_q   <= pwdata[FAST_W-1:0];
				REG_STEADY: steady_q <= pwdata[STEADY_W-1:0];
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[2])
			REG_FAST:   prdata = {{(32-FAST_W){1'b0}}, fast_q};
			REG_STEADY: prdata = {{(32-STEADY_W){1'b0}}, steady_q};
		endcase
	end

	// request sequencing
	fbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.status    (status)
	);

	assign out_ch.valid = out_valid;

	// phase state and draw unit
	fbs_datapath #(
		.MAX_SLEEP_SECONDS (MAX_SLEEP_SECONDS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.night_seen    (in_ch.night_seen),
		.fast_count    (fast_q),
		.steady_count  (steady_q),
		.blink_now     (out_ch.blink_now),
		.sleep_seconds (out_ch.sleep_seconds),
		.check_after   (out_ch.check_after)
	);

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the firefly blink sequencer core: wake-up requests
// are driven with random gaps and back-pressure, each result is checked field
// by field against a behavioural copy of the sequencer, and both registers are
// exercised over the apb port with read-back
// ----------------------------------------------------------------------------
module tb
	import fbs_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_SLEEP    = 8;
	localparam int unsigned WAKE_TARGET  = 1650;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned TAIL_CYCLES  = 300;
	localparam int unsigned RX_HOLD      = 400;

	localparam logic [2:0] ADDR_FAST   = {REG_FAST, 2'b00};
	localparam logic [2:0] ADDR_STEADY = {REG_STEADY, 2'b00};

	typedef struct packed {
		logic               blink_now;
		logic [SLEEP_W-1:0] sleep_seconds;
		logic               check_after;
	} wake_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	fbs_in_if  in_ch ();
	fbs_out_if out_ch ();

	firefly_blink_sequencer_core #(
		.MAX_SLEEP_SECONDS(MAX_SLEEP)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// sequencer copy: configuration and state
	logic [FAST_W-1:0]   fast_cnt   = FAST_RESET;
	logic [STEADY_W-1:0] steady_cnt = STEADY_RESET;
	phase_t              seq_phase  = PH_DAY;
	logic [LOOP_W-1:0]   loop_cnt   = '0;
	logic [BOUND_W-1:0]  lo_bound   = 4'd1;
	logic [BOUND_W-1:0]  hi_bound   = 4'd2;
	logic [WIDEN_W-1:0]  widen      = '0;
	logic [GEN_W-1:0]    gen_step   = GEN_STEP_SEED;
	logic [GEN_W-1:0]    gen_mix    = GEN_MIX_SEED;
	logic [GEN_W-1:0]    gen_sum    = GEN_SUM_SEED;
	logic [GEN_W-1:0]    gen_out    = GEN_OUT_SEED;
	logic [SLEEP_W-1:0]  next_sleep = SLEEP_W'(MAX_SLEEP);
	logic                next_check = 1'b1;

	wake_result_t pending_results[$];
	wake_result_t want;
	int unsigned  mismatches  = 0;
	int unsigned  wakes_sent  = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  rx_hold_req = 0;
	int unsigned  rx_hold_left = 0;
	bit           flow_mode   = 1'b0;

	// one step of the xabc generator
	function automatic logic [GEN_W-1:0] xabc_next();
		gen_step = gen_step + 1'b1;
		gen_mix  = gen_mix ^ gen_out ^ gen_step;
		gen_sum  = gen_sum + gen_mix;
		gen_out  = gen_out + ((gen_sum >> 1) ^ gen_mix);
		return gen_out;
	endfunction

	// uniform draw in 0..n-1 by masking and rejection, 0 after 256 tries
	function automatic logic [BOUND_W-1:0] draw_under(input logic [BOUND_W-1:0] n);
		logic [GEN_W-1:0] mask;
		logic [GEN_W-1:0] v;
		mask = (n <= 2) ? 8'd1 : ((n <= 4) ? 8'd3 : 8'd7);
		for (int k = 0; k < 256; k++) begin
			v = xabc_next() & mask;
			if (v < n)
				return v[BOUND_W-1:0];
		end
		return '0;
	endfunction

	function automatic void back_to_day();
		seq_phase  = PH_DAY;
		next_sleep = SLEEP_W'(MAX_SLEEP);
		next_check = 1'b1;
	endfunction

	// 1 s sleep, plus a second when the draw is at or below the blink number
	function automatic void schedule_extra();
		next_sleep = (draw_under(4'd8) <= loop_cnt) ? 4'd2 : 4'd1;
		next_check = 1'b1;
	endfunction

	function automatic void schedule_interval();
		next_sleep = lo_bound + draw_under(hi_bound - lo_bound + 1'b1);
		next_check = 1'b1;
	endfunction

	function automatic void enter_interval();
		seq_phase = PH_INTERVAL;
		lo_bound  = 4'd1;
		hi_bound  = 4'd2;
		widen     = '0;
		schedule_interval();
	endfunction

	function automatic void enter_extra();
		if (fast_cnt == 0) begin
			enter_interval();
		end else begin
			seq_phase = PH_RANDX;
			loop_cnt  = '0;
			schedule_extra();
		end
	endfunction

	// advance the sequencer copy by one accepted request, queue its result
	function automatic void predict_wake(input logic night);
		logic blink;
		blink = 1'b0;
		case (seq_phase)
			PH_FAST: begin
				blink    = 1'b1;
				loop_cnt = loop_cnt + 1'b1;
				if (loop_cnt >= fast_cnt) begin
					enter_extra();
				end else begin
					next_sleep = 4'd1;
					next_check = 1'b0;
				end
			end
			PH_RANDX: begin
				if (!night) begin
					back_to_day();
				end else begin
					blink    = 1'b1;
					loop_cnt = loop_cnt + 1'b1;
					if (loop_cnt >= fast_cnt)
						enter_interval();
					else
						schedule_extra();
				end
			end
			PH_INTERVAL: begin
				if (!night) begin
					back_to_day();
				end else begin
					blink = 1'b1;
					widen = widen + 1'b1;
					if (widen[1:0] == 2'd0 && hi_bound < MAX_SLEEP)
						hi_bound = hi_bound + 1'b1;
					if (widen[2:0] == 3'd0)
						lo_bound = lo_bound + 1'b1;
					if (lo_bound < MAX_SLEEP) begin
						schedule_interval();
					end else begin
						loop_cnt   = '0;
						seq_phase  = (steady_cnt == 0) ? PH_REST : PH_STEADY;
						next_sleep = SLEEP_W'(MAX_SLEEP);
						next_check = 1'b1;
					end
				end
			end
			PH_STEADY: begin
				if (!night) begin
					back_to_day();
				end else begin
					blink    = 1'b1;
					loop_cnt = loop_cnt + 1'b1;
					if (loop_cnt >= steady_cnt)
						seq_phase = PH_REST;
					next_sleep = SLEEP_W'(MAX_SLEEP);
					next_check = 1'b1;
				end
			end
			PH_REST: begin
				if (!night) begin
					back_to_day();
				end else begin
					next_sleep = SLEEP_W'(MAX_SLEEP);
					next_check = 1'b1;
				end
			end
			default: begin
				if (!night) begin
					back_to_day();
				end else if (fast_cnt == 0) begin
					enter_extra();
				end else begin
					seq_phase  = PH_FAST;
					loop_cnt   = '0;
					next_sleep = 4'd1;
					next_check = 1'b0;
				end
			end
		endcase
		pending_results.push_back('{blink, next_sleep, next_check});
	endfunction

	// night flag: free when no check is pending, else day at the given rate
	function automatic logic pick_night(input int unsigned day_pm);
		if (!next_check)
			return 1'($urandom_range(1));
		return $urandom_range(999) >= day_pm;
	endfunction

	function automatic void report_field(input string name, input logic [3:0] exp_v,
		input logic [3:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual blink %0b sleep %0d check %0b",
					$time, out_ch.blink_now, out_ch.sleep_seconds, out_ch.check_after);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				report_field("blink_now", 4'(want.blink_now), 4'(out_ch.blink_now));
				report_field("sleep_seconds", want.sleep_seconds, out_ch.sleep_seconds);
				report_field("check_after", 4'(want.check_after), 4'(out_ch.check_after));
			end
		end
	end

	// result receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req  = 0;
		end
		if (rx_hold_left != 0) begin
			out_ch.ready <= 1'b0;
			rx_hold_left--;
		end else begin
			out_ch.ready <= flow_mode || ($urandom_range(99) >= 10);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one apb transfer: setup then access, then idle, ending on a falling edge
	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_reg(input logic [2:0] addr);
		logic [31:0] got;
		logic [15:0] exp_v;
		logic [15:0] seen;
		apb_access(1'b0, addr, $urandom, got);
		if (addr == ADDR_FAST) begin
			exp_v = 16'(fast_cnt);
			seen  = 16'(got[FAST_W-1:0]);
		end else begin
			exp_v = steady_cnt;
			seen  = got[STEADY_W-1:0];
		end
		if (seen !== exp_v) begin
			$display("%0t: register %0d read-back, expected %0d, actual %0d",
				$time, addr, exp_v, seen);
			mismatches++;
		end
	endtask

	// stop offering requests and wait for every result to come back
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// write a register once the block is idle, random bits above the field
	task automatic program_reg(input logic [2:0] addr, input logic [15:0] value);
		logic [31:0] data;
		logic [31:0] unused;
		drain_results();
		data = $urandom;
		if (addr == ADDR_FAST) begin
			data[FAST_W-1:0] = value[FAST_W-1:0];
			fast_cnt         = value[FAST_W-1:0];
		end else begin
			data[STEADY_W-1:0] = value;
			steady_cnt         = value;
		end
		apb_access(1'b1, addr, data, unused);
		check_reg(addr);
	endtask

	// offer one wake-up request and hold it until accepted
	task automatic send_wake(input logic night);
		if (!flow_mode && $urandom_range(99) < 10) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(negedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.night_seen <= night;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_wake(night);
		wakes_sent++;
		@(negedge clk);
	endtask

	task automatic test_reset_values();
		check_reg(ADDR_FAST);
		check_reg(ADDR_STEADY);
	endtask

	// short walk through day, fast, random-extra and interval phases
	task automatic test_directed();
		send_wake(1'b0);
		send_wake(1'b1);
		// fast blinks ignore the flag
		for (int i = 0; i < 4; i++)
			send_wake(i[0]);
		send_wake(1'b1);
		send_wake(1'b0);
		// zero fast count skips straight to the interval phase
		program_reg(ADDR_FAST, 16'd0);
		send_wake(1'b1);
		repeat (3)
			send_wake(1'b1);
		send_wake(1'b0);
		// widest fast count
		program_reg(ADDR_FAST, 16'd15);
		send_wake(1'b1);
		repeat (3)
			send_wake(1'b0);
		program_reg(ADDR_FAST, 16'(FAST_RESET));
	endtask

	task automatic test_register_extremes();
		program_reg(ADDR_STEADY, 16'hFFFF);
		program_reg(ADDR_STEADY, 16'd0);
		program_reg(ADDR_FAST, 16'd15);
		program_reg(ADDR_FAST, 16'd0);
		program_reg(ADDR_STEADY, 16'(STEADY_RESET));
		program_reg(ADDR_FAST, 16'(FAST_RESET));
	endtask

	// counts lowered below the running count end the phase at once
	task automatic test_shrink_counts();
		program_reg(ADDR_FAST, 16'd15);
		program_reg(ADDR_STEADY, 16'hFFFF);
		do
			send_wake(1'b0);
		while (seq_phase != PH_DAY);
		while (!(seq_phase == PH_FAST && loop_cnt >= 10))
			send_wake(pick_night(0));
		program_reg(ADDR_FAST, 16'd3);
		while (!(seq_phase == PH_STEADY && loop_cnt >= 6))
			send_wake(pick_night(0));
		program_reg(ADDR_STEADY, 16'd2);
		repeat (4)
			send_wake(1'b1);
		send_wake(1'b0);
	endtask

	// receiver holds off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		drain_results();
		rx_hold_req = RX_HOLD;
		repeat (20)
			send_wake(pick_night(20));
	endtask

	// sender pauses until every result is back, then carries on
	task automatic test_drain_pause();
		repeat (12)
			send_wake(pick_night(20));
		drain_results();
		repeat (12)
			send_wake(pick_night(20));
	endtask

	// random nights under random settings, mostly unbroken night runs
	task automatic test_night_runs();
		int unsigned seg;
		int unsigned day_pm;
		int unsigned run_len;
		logic [15:0] fast_v;
		logic [15:0] steady_v;
		seg = 0;
		while (wakes_sent < WAKE_TARGET) begin
			case ($urandom_range(9))
				0:       fast_v = 16'd0;
				1:       fast_v = 16'd15;
				2:       fast_v = 16'd1;
				default: fast_v = 16'($urandom_range(15));
			endcase
			case ($urandom_range(11))
				0:       steady_v = 16'd0;
				1:       steady_v = 16'd1;
				2:       steady_v = 16'hFFFF;
				3:       steady_v = 16'($urandom_range(65535));
				default: steady_v = 16'($urandom_range(2, 40));
			endcase
			program_reg(ADDR_FAST, fast_v);
			program_reg(ADDR_STEADY, steady_v);
			case ($urandom_range(5))
				0, 1:    day_pm = 0;
				2:       day_pm = 5;
				3:       day_pm = 20;
				4:       day_pm = 300;
				default: day_pm = 2;
			endcase
			// one long stretch with no idling on either side
			flow_mode = (seg == 2);
			run_len   = flow_mode ? 250 : $urandom_range(30, 150);
			repeat (run_len)
				send_wake(pick_night(day_pm));
			flow_mode = 1'b0;
			seg++;
		end
	endtask

	// reset, tests in turn, drain and verdict
	initial begin
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.night_seen = 1'b0;
		out_ch.ready     = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_directed();
		test_register_extremes();
		test_backpressure();
		test_drain_pause();
		test_shrink_counts();
		test_night_runs();

		drain_results();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
